// ===== hdl/pmcr_pkg.sv =====
// package for the page migration channel remap block
// holds field widths, action, status and phase codes, and controller/datapath structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package pmcr_pkg;

  localparam int KEY_W   = 42;
  localparam int CHAN_W  = 4;
  localparam int PHASE_W = 2;
  localparam int ENTRY_W = KEY_W + CHAN_W + PHASE_W;
  localparam int DEFAULT_TABLE_ENTRIES = 64;

  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_START  = 2'd1;
  localparam logic [1:0] ACT_SET    = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BUSY      = 3'd1;
  localparam logic [2:0] ST_ABSENT    = 3'd2;
  localparam logic [2:0] ST_UNCHANGED = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam logic [1:0] PH_READING  = 2'd0;
  localparam logic [1:0] PH_BUFFERED = 2'd1;
  localparam logic [1:0] PH_WRITING  = 2'd2;
  localparam logic [1:0] PH_DONE     = 2'd3;

  localparam logic [1:0] REG_CHANNELS  = 2'd0;
  localparam logic [1:0] REG_BANKS     = 2'd1;
  localparam logic [1:0] REG_RANKS     = 2'd2;
  localparam logic [1:0] REG_SUBARRAYS = 2'd3;

  typedef struct packed {
    logic load;
    logic key_en;
    logic scan_en;
    logic wr1;
    logic wr2;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic key_last;
    logic scan_done;
  } stat_t;

endpackage
`default_nettype wire

// ===== hdl/page_migration_channel_remap.sv =====
// top level of the page migration channel remap block
// depends on pmcr_pkg, pmcr_regs, pmcr_ctrl and pmcr_dp
//
// A command is taken at a rising edge with start high and busy low. action selects
// lookup, start migration (page and partner swap channels) or set phase. Each
// command gives exactly one result: done is high for one cycle with status,
// out_channel, is_migrated, is_buffered, busy_res and remapped_count valid in it.
// The receiver cannot stall; the result is taken in that cycle.
// A command runs from the accepting edge through the key build, in which the two
// mixed-radix keys are built on one multiply-add unit, the scan of the remap table
// memory at one entry per cycle, the table writes in S_WR1 and S_WR2 and the
// result in S_FIN. busy is high the whole time, so the next command can be
// taken in the done cycle.
// Radix registers sit on the apb-style port at byte addresses 0, 4, 8, 12. The user
// must write them only while busy is low; the block itself does not enforce it.
// Reset clears the table valid bits, the in-flight migration and the counter,
// and loads the radix registers with 2 channels, 8 banks, 1 rank, 1 subarray.
`timescale 1ns / 1ps
`default_nettype none
module page_migration_channel_remap #(
  parameter int TABLE_ENTRIES = pmcr_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  action,
  input  wire logic [19:0] page_row,
  input  wire logic [5:0]  page_bank,
  input  wire logic [3:0]  page_rank,
  input  wire logic [7:0]  page_subarray,
  input  wire logic [3:0]  page_channel,
  input  wire logic [19:0] partner_row,
  input  wire logic [5:0]  partner_bank,
  input  wire logic [3:0]  partner_rank,
  input  wire logic [7:0]  partner_subarray,
  input  wire logic [3:0]  partner_channel,
  input  wire logic [1:0]  new_phase,
  output logic             done,
  output logic [2:0]       status,
  output logic [3:0]       out_channel,
  output logic             is_migrated,
  output logic             is_buffered,
  output logic             busy_res,
  output logic [31:0]      remapped_count,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import pmcr_pkg::*;

  cmd_t       cmd;
  stat_t      stat;
  logic [4:0] num_channels;
  logic [6:0] num_banks;
  logic [4:0] num_ranks;
  logic [8:0] num_subarrays;

  pmcr_regs u_regs (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .num_channels(num_channels), .num_banks(num_banks),
    .num_ranks(num_ranks), .num_subarrays(num_subarrays)
  );

  pmcr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .stat(stat)
  );

  pmcr_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .num_channels(num_channels), .num_banks(num_banks),
    .num_ranks(num_ranks), .num_subarrays(num_subarrays),
    .action(action),
    .page_row(page_row), .page_bank(page_bank), .page_rank(page_rank),
    .page_subarray(page_subarray), .page_channel(page_channel),
    .partner_row(partner_row), .partner_bank(partner_bank),
    .partner_rank(partner_rank), .partner_subarray(partner_subarray),
    .partner_channel(partner_channel), .new_phase(new_phase),
    .done(done), .status(status), .out_channel(out_channel),
    .is_migrated(is_migrated), .is_buffered(is_buffered),
    .busy_res(busy_res), .remapped_count(remapped_count)
  );

endmodule
`default_nettype wire

// ===== hdl/pmcr_regs.sv =====
// configuration registers with apb-style access
// depends on pmcr_pkg for register indexes
`timescale 1ns / 1ps
`default_nettype none
module pmcr_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [4:0]       num_channels,
  output logic [6:0]       num_banks,
  output logic [4:0]       num_ranks,
  output logic [8:0]       num_subarrays
);
  import pmcr_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_channels  <= 5'd2;
      num_banks     <= 7'd8;
      num_ranks     <= 5'd1;
      num_subarrays <= 9'd1;
    end else if (wr) begin
      case (paddr[3:2])
        REG_CHANNELS:  num_channels  <= pwdata[4:0];
        REG_BANKS:     num_banks     <= pwdata[6:0];
        REG_RANKS:     num_ranks     <= pwdata[4:0];
        REG_SUBARRAYS: num_subarrays <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CHANNELS:  prdata = {27'd0, num_channels};
      REG_BANKS:     prdata = {25'd0, num_banks};
      REG_RANKS:     prdata = {27'd0, num_ranks};
      REG_SUBARRAYS: prdata = {23'd0, num_subarrays};
      default:       prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/pmcr_ctrl.sv =====
// controller state machine: key build, table scan, table writes, result
// depends on pmcr_pkg for the command and status structs
`timescale 1ns / 1ps
`default_nettype none
module pmcr_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  output pmcr_pkg::cmd_t      cmd,
  input  wire pmcr_pkg::stat_t stat
);
  import pmcr_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_KEY, S_SCAN, S_WR1, S_WR2, S_FIN} state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_KEY;
      S_KEY:  if (stat.key_last) state_next = S_SCAN;
      S_SCAN: if (stat.scan_done) state_next = S_WR1;
      S_WR1:  state_next = S_WR2;
      S_WR2:  state_next = S_FIN;
      S_FIN:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.load    = (state == S_IDLE) && start;
    cmd.key_en  = (state == S_KEY);
    cmd.scan_en = (state == S_SCAN);
    cmd.wr1     = (state == S_WR1);
    cmd.wr2     = (state == S_WR2);
    cmd.fin     = (state == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pmcr_dp.sv =====
// datapath: shared key multiply-add unit, remap table memory, scan and result logic
// depends on pmcr_pkg for widths, codes and the command and status structs
`timescale 1ns / 1ps
`default_nettype none
module pmcr_dp #(
  parameter int TABLE_ENTRIES = pmcr_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pmcr_pkg::cmd_t   cmd,
  output pmcr_pkg::stat_t       stat,
  input  wire logic [4:0]       num_channels,
  input  wire logic [6:0]       num_banks,
  input  wire logic [4:0]       num_ranks,
  input  wire logic [8:0]       num_subarrays,
  input  wire logic [1:0]       action,
  input  wire logic [19:0]      page_row,
  input  wire logic [5:0]       page_bank,
  input  wire logic [3:0]       page_rank,
  input  wire logic [7:0]       page_subarray,
  input  wire logic [3:0]       page_channel,
  input  wire logic [19:0]      partner_row,
  input  wire logic [5:0]       partner_bank,
  input  wire logic [3:0]       partner_rank,
  input  wire logic [7:0]       partner_subarray,
  input  wire logic [3:0]       partner_channel,
  input  wire logic [1:0]       new_phase,
  output logic                  done,
  output logic [2:0]            status,
  output logic [3:0]            out_channel,
  output logic                  is_migrated,
  output logic                  is_buffered,
  output logic                  busy_res,
  output logic [31:0]           remapped_count
);
  import pmcr_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // captured item
  logic [1:0]  act;
  logic [19:0] p_row, d_row;
  logic [5:0]  p_bank, d_bank;
  logic [3:0]  p_rank, d_rank;
  logic [7:0]  p_sub, d_sub;
  logic [3:0]  p_chan, d_chan;
  logic [1:0]  nph;

  // key unit
  logic [2:0]        kstep;
  logic [KEY_W-1:0]  acc, pkey, dkey;
  logic [KEY_W-1:0]  base;
  logic [8:0]        radix;
  logic [7:0]        field;
  logic [KEY_W+8:0]  prod;
  logic [KEY_W-1:0]  kval;

  // table
  logic [ENTRY_W-1:0]      mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid;
  logic [ENTRY_W-1:0]      rdata;
  logic [AW:0]             scnt;
  logic [AW-1:0]           rd_idx;
  logic                    rd_v;
  logic [KEY_W-1:0]        e_key;
  logic [CHAN_W-1:0]       e_chan;
  logic [PHASE_W-1:0]      e_phase;

  // scan results
  logic          phit, dhit, prhit, dmhit, f0, f1;
  logic [AW-1:0] pidx, didx, pridx, dmidx, f0idx, f1idx;
  logic [3:0]    pchan_e;
  logic [1:0]    pphase, prphase, dmphase;

  // migration state
  logic             busy_flag;
  logic [KEY_W-1:0] promoted_key, demoted_key;
  logic [31:0]      remap_counter;

  // decisions
  logic               need_p, need_d, room, start_ok, set_ok, same_key;
  logic               pr_done, dm_done, migrated;
  logic [AW-1:0]      idx_start1, idx1, idx2, widx;
  logic [ENTRY_W-1:0] data1, data2, wdata;
  logic               we1, we2, we;
  logic [1:0]         pr_ph, dm_ph;
  logic               busy_flag_next;
  logic [31:0]        counter_next;
  logic [2:0]         status_next;

  // one multiply-add step of the mixed-radix key per cycle, page key then partner key
  always_comb begin
    base = (kstep[1:0] == 2'd0) ? KEY_W'(kstep[2] ? d_row : p_row) : acc;
    case (kstep[1:0])
      2'd0: begin
        radix = {2'd0, num_banks};
        field = {2'd0, kstep[2] ? d_bank : p_bank};
      end
      2'd1: begin
        radix = {4'd0, num_ranks};
        field = {4'd0, kstep[2] ? d_rank : p_rank};
      end
      2'd2: begin
        radix = num_subarrays;
        field = kstep[2] ? d_sub : p_sub;
      end
      default: begin
        radix = {4'd0, num_channels};
        field = {4'd0, kstep[2] ? d_chan : p_chan};
      end
    endcase
    prod = {9'd0, base} * {{KEY_W{1'b0}}, radix};
    kval = prod[KEY_W-1:0] + KEY_W'(field);
  end

  assign stat.key_last  = (kstep == 3'd7);
  assign stat.scan_done = (scnt == (AW+1)'(TABLE_ENTRIES)) && !rd_v;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act    <= action;
      p_row  <= page_row;      d_row  <= partner_row;
      p_bank <= page_bank;     d_bank <= partner_bank;
      p_rank <= page_rank;     d_rank <= partner_rank;
      p_sub  <= page_subarray; d_sub  <= partner_subarray;
      p_chan <= page_channel;  d_chan <= partner_channel;
      nph    <= new_phase;
      kstep  <= 3'd0;
    end else if (cmd.key_en) begin
      acc   <= kval;
      kstep <= kstep + 3'd1;
      if (kstep == 3'd3) pkey <= kval;
      if (kstep == 3'd7) dkey <= kval;
    end
  end

  assign e_key   = rdata[ENTRY_W-1 -: KEY_W];
  assign e_chan  = rdata[PHASE_W +: CHAN_W];
  assign e_phase = rdata[PHASE_W-1:0];

  // one table entry read per cycle, compared against up to four keys
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
      scnt <= '0;
    end else if (cmd.load) begin
      rd_v <= 1'b0;
      scnt <= '0;
    end else if (cmd.scan_en) begin
      rd_v <= (scnt != (AW+1)'(TABLE_ENTRIES));
      if (scnt != (AW+1)'(TABLE_ENTRIES)) scnt <= scnt + (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      phit <= 1'b0; dhit <= 1'b0; prhit <= 1'b0; dmhit <= 1'b0;
      f0 <= 1'b0; f1 <= 1'b0;
    end else if (cmd.scan_en) begin
      rd_idx <= scnt[AW-1:0];
      if (rd_v) begin
        if (valid[rd_idx]) begin
          if (!phit && e_key == pkey) begin
            phit <= 1'b1; pidx <= rd_idx; pchan_e <= e_chan; pphase <= e_phase;
          end
          if (!dhit && e_key == dkey) begin
            dhit <= 1'b1; didx <= rd_idx;
          end
          if (!prhit && e_key == promoted_key) begin
            prhit <= 1'b1; pridx <= rd_idx; prphase <= e_phase;
          end
          if (!dmhit && e_key == demoted_key) begin
            dmhit <= 1'b1; dmidx <= rd_idx; dmphase <= e_phase;
          end
        end else if (!f0) begin
          f0 <= 1'b1; f0idx <= rd_idx;
        end else if (!f1) begin
          f1 <= 1'b1; f1idx <= rd_idx;
        end
      end
    end
  end

  always_comb begin
    same_key = (dkey == pkey);
    need_p   = !phit;
    need_d   = !same_key && !dhit;
    if (need_p && need_d)      room = f1;
    else if (need_p || need_d) room = f0;
    else                       room = 1'b1;
    start_ok = (act == ACT_START) && !busy_flag && room;
    set_ok   = (act == ACT_SET) && phit && (pphase != nph);

    idx_start1 = phit ? pidx : f0idx;
    if (act == ACT_SET) begin
      idx1  = pidx;
      data1 = {pkey, pchan_e, nph};
    end else begin
      idx1  = idx_start1;
      data1 = {pkey, d_chan, PH_READING};
    end
    if (same_key)  idx2 = idx_start1;
    else if (dhit) idx2 = didx;
    else if (phit) idx2 = f0idx;
    else           idx2 = f1idx;
    data2 = {dkey, p_chan, PH_READING};

    we1   = cmd.wr1 && (start_ok || set_ok);
    we2   = cmd.wr2 && start_ok;
    we    = we1 || we2;
    widx  = we2 ? idx2 : idx1;
    wdata = we2 ? data2 : data1;

    // completion check sees the phase just written
    pr_ph   = (pridx == pidx) ? nph : prphase;
    dm_ph   = (dmidx == pidx) ? nph : dmphase;
    pr_done = prhit && (pr_ph == PH_DONE);
    dm_done = dmhit && (dm_ph == PH_DONE);

    migrated = (act == ACT_LOOKUP) && phit && (pphase == PH_DONE);

    busy_flag_next = busy_flag;
    if (start_ok) busy_flag_next = 1'b1;
    else if (set_ok && pr_done && dm_done) busy_flag_next = 1'b0;
    counter_next = migrated ? remap_counter + 32'd1 : remap_counter;

    case (act)
      ACT_START: begin
        if (busy_flag) status_next = ST_BUSY;
        else if (!room) status_next = ST_FULL;
        else status_next = ST_OK;
      end
      ACT_SET: begin
        if (!phit) status_next = ST_ABSENT;
        else if (pphase == nph) status_next = ST_UNCHANGED;
        else status_next = ST_OK;
      end
      default: status_next = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[widx] <= wdata;
    rdata <= mem[scnt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= '0;
      busy_flag     <= 1'b0;
      promoted_key  <= '0;
      demoted_key   <= '0;
      remap_counter <= '0;
      done          <= 1'b0;
    end else begin
      if (we) valid[widx] <= 1'b1;
      done <= cmd.fin;
      if (cmd.fin) begin
        busy_flag     <= busy_flag_next;
        remap_counter <= counter_next;
        if (start_ok) begin
          promoted_key <= pkey;
          demoted_key  <= dkey;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      status         <= status_next;
      out_channel    <= (act == ACT_LOOKUP) ? (migrated ? pchan_e : p_chan) : 4'd0;
      is_migrated    <= migrated;
      is_buffered    <= (act == ACT_LOOKUP) && phit &&
                        (pphase == PH_BUFFERED || pphase == PH_WRITING);
      busy_res       <= busy_flag_next;
      remapped_count <= counter_next;
    end
  end

endmodule
`default_nettype wire

// ===== test/tb_page_migration_channel_remap.sv =====
// testbench for the page migration channel remap block
// drives commands and radix register writes, predicts every result, checks each done transfer
// depends on pmcr_pkg and page_migration_channel_remap
`timescale 1ns / 1ps
`default_nettype none
module tb_page_migration_channel_remap;
  import pmcr_pkg::*;

  localparam int ENTRIES = DEFAULT_TABLE_ENTRIES;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  chan;
    logic        migrated;
    logic        buffered;
    logic        busy;
    logic [31:0] count;
  } remap_res_t;

  typedef struct {
    logic [1:0]  act;
    logic [19:0] prow, qrow;
    logic [5:0]  pbank, qbank;
    logic [3:0]  prank, qrank;
    logic [7:0]  psub, qsub;
    logic [3:0]  pchan, qchan;
    logic [1:0]  phase;
  } remap_cmd_t;

  class remap_scoreboard;
    logic [63:0] radix [4];
    bit          valid [ENTRIES];
    logic [41:0] key [ENTRIES];
    logic [3:0]  chan [ENTRIES];
    logic [1:0]  phase [ENTRIES];
    bit          in_flight;
    logic [41:0] promoted, demoted;
    logic [31:0] count;
    remap_res_t  pending[$];
    int          errors;

    function new();
      radix[REG_CHANNELS] = 2; radix[REG_BANKS] = 8;
      radix[REG_RANKS] = 1; radix[REG_SUBARRAYS] = 1;
      foreach (valid[i]) valid[i] = 0;
      in_flight = 0; promoted = 0; demoted = 0; count = 0; errors = 0;
    endfunction

    function logic [41:0] page_key(logic [19:0] r, logic [5:0] b, logic [3:0] k,
                                   logic [7:0] s, logic [3:0] c);
      logic [63:0] acc;
      acc = 64'(r);
      acc = acc * radix[REG_BANKS] + 64'(b);
      acc = acc * radix[REG_RANKS] + 64'(k);
      acc = acc * radix[REG_SUBARRAYS] + 64'(s);
      acc = acc * radix[REG_CHANNELS] + 64'(c);
      return acc[41:0];
    endfunction

    function int slot_of(logic [41:0] k);
      for (int i = 0; i < ENTRIES; i++) if (valid[i] && key[i] == k) return i;
      return -1;
    endfunction

    function int free_slots();
      int n;
      n = 0;
      foreach (valid[i]) if (!valid[i]) n++;
      return n;
    endfunction

    function void map_page(logic [41:0] k, logic [3:0] c);
      int i;
      i = slot_of(k);
      if (i < 0) begin
        for (i = 0; i < ENTRIES; i++) if (!valid[i]) break;
        valid[i] = 1; key[i] = k;
      end
      chan[i] = c; phase[i] = PH_READING;
    endfunction

    function bit page_done(logic [41:0] k);
      int i;
      i = slot_of(k);
      return i >= 0 && phase[i] == PH_DONE;
    endfunction

    function void note_command(remap_cmd_t c);
      remap_res_t r;
      logic [41:0] pk, dk;
      int i, need;
      r = '0;
      pk = page_key(c.prow, c.pbank, c.prank, c.psub, c.pchan);
      i = slot_of(pk);
      case (c.act)
        ACT_LOOKUP: begin
          r.chan = c.pchan;
          if (i >= 0) begin
            if (phase[i] == PH_DONE) begin
              r.migrated = 1; r.chan = chan[i]; count++;
            end else if (phase[i] == PH_BUFFERED || phase[i] == PH_WRITING)
              r.buffered = 1;
          end
        end
        ACT_START: begin
          dk = page_key(c.qrow, c.qbank, c.qrank, c.qsub, c.qchan);
          if (in_flight) r.status = ST_BUSY;
          else begin
            need = (i < 0) + (dk != pk && slot_of(dk) < 0);
            if (need > free_slots()) r.status = ST_FULL;
            else begin
              map_page(pk, c.qchan);
              map_page(dk, c.pchan);
              in_flight = 1; promoted = pk; demoted = dk;
            end
          end
        end
        ACT_SET: begin
          if (i < 0) r.status = ST_ABSENT;
          else if (phase[i] == c.phase) r.status = ST_UNCHANGED;
          else begin
            phase[i] = c.phase;
            if (page_done(promoted) && page_done(demoted)) in_flight = 0;
          end
        end
        default: ;
      endcase
      r.busy = in_flight;
      r.count = count;
      pending.push_back(r);
    endfunction

    function void check_result(remap_res_t got);
      remap_res_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status)
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      if (got.chan !== want.chan)
        $display("%0t: out_channel expected %0d actual %0d", $time, want.chan, got.chan);
      if (got.migrated !== want.migrated)
        $display("%0t: is_migrated expected %0b actual %0b", $time, want.migrated,
                 got.migrated);
      if (got.buffered !== want.buffered)
        $display("%0t: is_buffered expected %0b actual %0b", $time, want.buffered,
                 got.buffered);
      if (got.busy !== want.busy)
        $display("%0t: busy_res expected %0b actual %0b", $time, want.busy, got.busy);
      if (got.count !== want.count)
        $display("%0t: remapped_count expected %0d actual %0d", $time, want.count,
                 got.count);
      if (got !== want) errors++;
    endfunction
  endclass

  logic clk = 0, rst = 1, start = 0;
  logic busy, done;
  logic [1:0] action = '0, new_phase = '0;
  logic [19:0] page_row = '0, partner_row = '0;
  logic [5:0] page_bank = '0, partner_bank = '0;
  logic [3:0] page_rank = '0, partner_rank = '0, page_channel = '0, partner_channel = '0;
  logic [7:0] page_subarray = '0, partner_subarray = '0;
  logic [2:0] status;
  logic [3:0] out_channel;
  logic is_migrated, is_buffered, busy_res;
  logic [31:0] remapped_count;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;

  remap_scoreboard board = new();
  remap_cmd_t hot [8];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  page_migration_channel_remap i_dut (.*);

  always @(posedge clk)
    if (!rst && done)
      board.check_result('{status, out_channel, is_migrated, is_buffered, busy_res,
                           remapped_count});

  task automatic write_radix(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    board.radix[idx] = 64'(val[8:0]) & (idx == REG_BANKS ? 64'h7f :
                        idx == REG_SUBARRAYS ? 64'h1ff : 64'h1f);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic issue(remap_cmd_t c);
    @(negedge clk);
    start <= 1; action <= c.act; new_phase <= c.phase;
    page_row <= c.prow; page_bank <= c.pbank; page_rank <= c.prank;
    page_subarray <= c.psub; page_channel <= c.pchan;
    partner_row <= c.qrow; partner_bank <= c.qbank; partner_rank <= c.qrank;
    partner_subarray <= c.qsub; partner_channel <= c.qchan;
    do @(posedge clk); while (busy);
    board.note_command(c);
    @(negedge clk);
    start <= 0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (ENTRIES + 20) @(posedge clk);
  endtask

  function automatic remap_cmd_t fresh_cmd();
    remap_cmd_t c;
    c.act = $urandom; c.phase = $urandom;
    c.prow = $urandom; c.pbank = $urandom; c.prank = $urandom;
    c.psub = $urandom; c.pchan = $urandom;
    c.qrow = $urandom; c.qbank = $urandom; c.qrank = $urandom;
    c.qsub = $urandom; c.qchan = $urandom;
    return c;
  endfunction

  function automatic remap_cmd_t rand_cmd();
    remap_cmd_t c;
    int sel;
    c = fresh_cmd();
    // mostly reuse a small set of pages so sets and lookups hit the table
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      remap_cmd_t h;
      h = hot[$urandom_range(0, 7)];
      c.prow = h.prow; c.pbank = h.pbank; c.prank = h.prank; c.psub = h.psub;
      c.pchan = h.pchan;
      if (c.act == ACT_START && sel < 5) begin
        h = hot[$urandom_range(0, 7)];
        c.qrow = h.prow; c.qbank = h.pbank; c.qrank = h.prank; c.qsub = h.psub;
        c.qchan = h.pchan;
      end
    end
    if (c.act == ACT_NOP && $urandom_range(0, 3) != 0) c.act = ACT_LOOKUP;
    return c;
  endfunction

  task automatic run_phase(int n);
    remap_cmd_t c;
    foreach (hot[i]) hot[i] = fresh_cmd();
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 30)) @(negedge clk);
      c = rand_cmd();
      issue(c);
    end
  endtask

  initial begin
    remap_cmd_t c;
    logic [31:0] cfg [4][4];
    foreach (hot[i]) hot[i] = fresh_cmd();
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 0;

    // directed: swap, lookups before and after done, busy refusal, absent, unchanged
    c = '{ACT_START, 20'hfffff, 20'h0, 6'h3f, 6'h0, 4'hf, 4'h0, 8'hff, 8'h0,
           4'h1, 4'h0, PH_READING};
    issue(c);
    issue(c);
    c.act = ACT_LOOKUP; issue(c);
    c.act = ACT_SET; c.phase = PH_READING; issue(c);
    c.phase = PH_BUFFERED; issue(c);
    c.act = ACT_LOOKUP; issue(c);
    c.act = ACT_SET; c.phase = PH_DONE; issue(c);
    c.prow = 0; c.pbank = 0; c.prank = 0; c.psub = 0; c.pchan = 0; issue(c);
    c.act = ACT_LOOKUP; issue(c);
    c.prow = 20'hfffff; c.pbank = 6'h3f; c.prank = 4'hf; c.psub = 8'hff; c.pchan = 4'h1;
    issue(c);
    c.prow = 20'h12345; c.act = ACT_SET; issue(c);
    c.act = ACT_NOP; issue(c);
    // equal keys in one start
    c.act = ACT_START; c.qrow = c.prow; c.qbank = c.pbank; c.qrank = c.prank;
    c.qsub = c.psub; c.qchan = c.pchan; issue(c);
    c.act = ACT_SET; c.phase = PH_DONE; issue(c);
    c.act = ACT_LOOKUP; issue(c);
    // fill the table with starts, setting both pages of each to done so that no start is refused as busy
    for (int k = 0; k < 36; k++) begin
      c = rand_cmd(); c.act = ACT_START; c.phase = PH_DONE;
      issue(c);
      c.act = ACT_SET; issue(c);
      c.prow = c.qrow; c.pbank = c.qbank; c.prank = c.qrank; c.psub = c.qsub;
      c.pchan = c.qchan; issue(c);
    end
    drain();

    cfg = '{'{16, 64, 16, 256}, '{1, 1, 1, 1}, '{31, 127, 31, 511}, '{4, 8, 2, 0}};
    foreach (cfg[p]) begin
      for (int r = 0; r < 4; r++) write_radix(r[1:0], cfg[p][r]);
      run_phase(440);
      drain();
    end
    if (board.errors == 0 && board.pending.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #40ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire
